>>> hdl/mrrc_pkg.sv
// ----------------------------------------------------------------------------
// mrrc_pkg
// Types, codes and the CRC-16 byte update shared by the Modbus RTU
// read-input-registers response checker.
// ----------------------------------------------------------------------------
package mrrc_pkg;

  localparam logic [7:0]  FuncReadInput = 8'h04;
  localparam logic [15:0] CrcInit       = 16'hFFFF;
  localparam logic [15:0] CrcPoly       = 16'hA001;
  localparam logic [8:0]  FrameOverhead = 9'd5;
  localparam logic [8:0]  TrailerOffset = 9'd3;
  localparam logic [8:0]  CountMax      = 9'd511;

  localparam logic [7:0]  SlaveAddrReset = 8'd1;
  localparam logic [6:0]  RegCountReset  = 7'd1;

  localparam logic CfgSlaveAddr = 1'b0;
  localparam logic CfgRegCount  = 1'b1;

  localparam logic KindData   = 1'b0;
  localparam logic KindStatus = 1'b1;

  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StZeroCount = 3'd1;
  localparam logic [2:0] StLength    = 3'd2;
  localparam logic [2:0] StSlave     = 3'd3;
  localparam logic [2:0] StFunction  = 3'd4;
  localparam logic [2:0] StByteCount = 3'd5;
  localparam logic [2:0] StCrc       = 3'd6;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } in_req_t;

  typedef struct packed {
    logic        result_kind;
    logic [6:0]  register_index;
    logic [15:0] register_value;
    logic [2:0]  status;
  } out_req_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CrcPoly;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

>>> hdl/mrrc_frame_check.sv
// ----------------------------------------------------------------------------
// mrrc_frame_check
// Frame state and per-byte checks: header compare, CRC update, register
// assembly and the end-of-frame status decision.
// ----------------------------------------------------------------------------
module mrrc_frame_check (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  mrrc_pkg::in_req_t item_i,
  input  logic [7:0]        slave_addr_i,
  input  logic [6:0]        reg_count_i,
  output logic              res_valid_o,
  output mrrc_pkg::out_req_t res_o
);

  logic [8:0]  bytes_seen_q, bytes_seen_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  pending_q, pending_d;
  logic [7:0]  crc_low_q, crc_low_d;
  logic [2:0]  faults_q, faults_d;

  logic [8:0]  trailer;
  logic [8:0]  p_inc;
  logic [8:0]  p_off;
  logic [15:0] rx_crc;
  logic        res_hit;

  always_comb begin
    trailer      = {1'b0, reg_count_i, 1'b0} + mrrc_pkg::TrailerOffset;
    p_inc        = (bytes_seen_q == mrrc_pkg::CountMax) ? bytes_seen_q : bytes_seen_q + 9'd1;
    p_off        = bytes_seen_q - 9'd4;
    faults_d     = faults_q;
    crc_d        = crc_q;
    crc_low_d    = crc_low_q;
    pending_d    = pending_q;
    bytes_seen_d = bytes_seen_q;
    res_hit      = 1'b0;
    res_o        = '0;

    if (bytes_seen_q == 9'd0 && item_i.rx_byte != slave_addr_i) begin
      faults_d[0] = 1'b1;
    end
    if (bytes_seen_q == 9'd1 && item_i.rx_byte != mrrc_pkg::FuncReadInput) begin
      faults_d[1] = 1'b1;
    end
    if (bytes_seen_q == 9'd2 && item_i.rx_byte != {reg_count_i, 1'b0}) begin
      faults_d[2] = 1'b1;
    end

    if (bytes_seen_q < trailer) begin
      crc_d = mrrc_pkg::crc_update(crc_q, item_i.rx_byte);
    end else if (bytes_seen_q == trailer) begin
      crc_low_d = item_i.rx_byte;
    end
    rx_crc = {item_i.rx_byte, crc_low_d};

    if (item_i.frame_end) begin
      res_hit           = 1'b1;
      res_o.result_kind = mrrc_pkg::KindStatus;
      if (reg_count_i == 7'd0) begin
        res_o.status = mrrc_pkg::StZeroCount;
      end else if (p_inc != {1'b0, reg_count_i, 1'b0} + mrrc_pkg::FrameOverhead) begin
        res_o.status = mrrc_pkg::StLength;
      end else if (faults_d[0]) begin
        res_o.status = mrrc_pkg::StSlave;
      end else if (faults_d[1]) begin
        res_o.status = mrrc_pkg::StFunction;
      end else if (faults_d[2]) begin
        res_o.status = mrrc_pkg::StByteCount;
      end else if (rx_crc != crc_d) begin
        res_o.status = mrrc_pkg::StCrc;
      end else begin
        res_o.status = mrrc_pkg::StOk;
      end
      bytes_seen_d = '0;
      crc_d        = mrrc_pkg::CrcInit;
      pending_d    = '0;
      crc_low_d    = '0;
      faults_d     = '0;
    end else begin
      bytes_seen_d = p_inc;
      if (bytes_seen_q >= 9'd3 && bytes_seen_q < trailer) begin
        if (bytes_seen_q[0]) begin
          pending_d = item_i.rx_byte;
        end else begin
          res_hit              = 1'b1;
          res_o.result_kind    = mrrc_pkg::KindData;
          res_o.register_index = p_off[7:1];
          res_o.register_value = {pending_q, item_i.rx_byte};
        end
      end
    end
  end

  assign res_valid_o = fire_i && res_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_seen_q <= '0;
      crc_q        <= mrrc_pkg::CrcInit;
      pending_q    <= '0;
      crc_low_q    <= '0;
      faults_q     <= '0;
    end else if (fire_i) begin
      bytes_seen_q <= bytes_seen_d;
      crc_q        <= crc_d;
      pending_q    <= pending_d;
      crc_low_q    <= crc_low_d;
      faults_q     <= faults_d;
    end
  end

endmodule

>>> hdl/modbus_register_response_checker_top.sv
// ----------------------------------------------------------------------------
// modbus_register_response_checker_top
// Checks a Modbus RTU read-input-registers response byte by byte, emits each
// data register as it completes and one status request per frame.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_ready_o  in_req_i  (rx_byte, frame_end)
// out       output     out_valid_o/out_ready_i out_req_o (kind, index, value, status)
// cfg       input      cfg_we_i               cfg_index_i, cfg_wdata_i
//
// Each byte waits in the input register and its result, if any, is then
// registered in the output register; one byte is taken every cycle unless
// the output stalls. The combinational CRC byte update sets the rate.
// Reset returns the frame state and the configuration to their reset values.
// A stalled output holds the pipeline; the input register still fills if empty.
// ----------------------------------------------------------------------------
module modbus_register_response_checker_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mrrc_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mrrc_pkg::out_req_t out_req_o,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [7:0]         cfg_wdata_i
);

  logic               s1_valid_q;
  mrrc_pkg::in_req_t  s1_req_q;
  logic               out_valid_q;
  mrrc_pkg::out_req_t out_req_q;
  logic [7:0]         slave_addr_q;
  logic [6:0]         reg_count_q;
  logic               advance;
  logic               res_valid;
  mrrc_pkg::out_req_t res;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= mrrc_pkg::SlaveAddrReset;
      reg_count_q  <= mrrc_pkg::RegCountReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mrrc_pkg::CfgSlaveAddr: slave_addr_q <= cfg_wdata_i;
        mrrc_pkg::CfgRegCount:  reg_count_q  <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_req_q <= in_req_i;
    end
  end

  mrrc_frame_check u_frame_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (advance),
    .item_i       (s1_req_q),
    .slave_addr_i (slave_addr_q),
    .reg_count_i  (reg_count_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_req_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

`ifndef SYNTH
  a_ready_low_means_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a blocked output");

  a_status_fields_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_req_o.result_kind == mrrc_pkg::KindStatus) |->
      (out_req_o.register_index == 7'd0 && out_req_o.register_value == 16'd0))
    else $error("status request carries register fields");

  a_data_status_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_req_o.result_kind == mrrc_pkg::KindData) |->
      (out_req_o.status == mrrc_pkg::StOk))
    else $error("data request carries a status");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_req_o.status != 3'd7))
    else $error("status code out of range");
`endif

endmodule

>>> tb/sv/tb_modbus_register_response_checker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modbus_register_response_checker_top
// Feeds Modbus RTU read-input-registers responses into the checker one byte
// at a time: good frames with random register contents, header, CRC and
// length faults, truncated, padded and oversized frames, and raw noise.
// A local model of the checker predicts every register and status request,
// and a monitor compares each one leaving the block, field by field, while
// both sides of the handshake idle and stall at random.
// ----------------------------------------------------------------------------
module tb_modbus_register_response_checker_top;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  mrrc_pkg::in_req_t   in_req_i    = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b1;
  mrrc_pkg::out_req_t  out_req_o;
  logic                cfg_we_i    = 1'b0;
  logic                cfg_index_i = 1'b0;
  logic [7:0]          cfg_wdata_i = '0;

  modbus_register_response_checker_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Local copy of the checker configuration and frame state.
  logic [7:0]  exp_slave;
  logic [6:0]  exp_count;
  logic [8:0]  frame_len;
  logic [15:0] crc_acc;
  logic [7:0]  high_byte;
  logic [7:0]  crc_low;
  logic [2:0]  hdr_faults;

  mrrc_pkg::out_req_t response_q[$];
  logic [7:0]         frame_buf[$];

  int errors       = 0;
  int bytes_sent   = 0;
  int frames_sent  = 0;
  int regs_seen    = 0;
  int status_seen  = 0;
  int status_tally[8];
  int burst_left   = 0;
  bit gaps_on      = 1'b1;
  int unsigned rx_cycle = 0;
  int stall_mode   = 0;

  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] d);
    logic [15:0] c;
    c = c_in ^ {8'h00, d};
    repeat (8) c = c[0] ? ({1'b0, c[15:1]} ^ mrrc_pkg::CrcPoly) : {1'b0, c[15:1]};
    return c;
  endfunction

  function automatic void clear_frame();
    frame_len  = '0;
    crc_acc    = mrrc_pkg::CrcInit;
    high_byte  = '0;
    crc_low    = '0;
    hdr_faults = '0;
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic fe);
    logic [8:0]         pos;
    logic [8:0]         trail;
    logic [8:0]         total;
    logic [8:0]         idx;
    logic [2:0]         st;
    mrrc_pkg::out_req_t r;
    pos   = frame_len;
    trail = {1'b0, exp_count, 1'b0} + mrrc_pkg::TrailerOffset;
    r     = '0;
    if (pos == 9'd0 && b != exp_slave) hdr_faults[0] = 1'b1;
    if (pos == 9'd1 && b != mrrc_pkg::FuncReadInput) hdr_faults[1] = 1'b1;
    if (pos == 9'd2 && b != {exp_count, 1'b0}) hdr_faults[2] = 1'b1;
    if (pos < trail) begin
      crc_acc = crc_byte(crc_acc, b);
    end else if (pos == trail) begin
      crc_low = b;
    end
    if (fe) begin
      total = (pos == mrrc_pkg::CountMax) ? mrrc_pkg::CountMax : pos + 9'd1;
      if (exp_count == 7'd0) st = mrrc_pkg::StZeroCount;
      else if (total != {1'b0, exp_count, 1'b0} + mrrc_pkg::FrameOverhead)
        st = mrrc_pkg::StLength;
      else if (hdr_faults[0]) st = mrrc_pkg::StSlave;
      else if (hdr_faults[1]) st = mrrc_pkg::StFunction;
      else if (hdr_faults[2]) st = mrrc_pkg::StByteCount;
      else if ({b, crc_low} != crc_acc) st = mrrc_pkg::StCrc;
      else st = mrrc_pkg::StOk;
      r.result_kind = mrrc_pkg::KindStatus;
      r.status      = st;
      response_q = {response_q, r};
      clear_frame();
    end else begin
      frame_len = (pos == mrrc_pkg::CountMax) ? mrrc_pkg::CountMax : pos + 9'd1;
      if (pos >= 9'd3 && pos < trail) begin
        if (pos[0]) begin
          high_byte = b;
        end else begin
          idx              = (pos - 9'd4) >> 1;
          r.result_kind    = mrrc_pkg::KindData;
          r.register_index = idx[6:0];
          r.register_value = {high_byte, b};
          response_q = {response_q, r};
        end
      end
    end
  endfunction

  always @(posedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 300 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 2) != 0);
      2: out_ready_i <= (rx_cycle[3:2] != 2'b11);
      default: out_ready_i <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    mrrc_pkg::out_req_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (response_q.size() == 0) begin
        $error("unexpected request: kind %0h index %0d value %04h status %0d",
               out_req_o.result_kind, out_req_o.register_index,
               out_req_o.register_value, out_req_o.status);
        errors++;
      end else begin
        want = response_q.pop_front();
        if (out_req_o.result_kind !== want.result_kind) begin
          $error("result_kind: expected %0h, got %0h", want.result_kind,
                 out_req_o.result_kind);
          errors++;
        end
        if (out_req_o.register_index !== want.register_index) begin
          $error("register_index: expected %0d, got %0d", want.register_index,
                 out_req_o.register_index);
          errors++;
        end
        if (out_req_o.register_value !== want.register_value) begin
          $error("register_value: expected %04h, got %04h", want.register_value,
                 out_req_o.register_value);
          errors++;
        end
        if (out_req_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_req_o.status);
          errors++;
        end
        if (want.result_kind == mrrc_pkg::KindStatus) begin
          status_seen++;
          status_tally[want.status]++;
        end else begin
          regs_seen++;
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fe);
    int gap;
    if (gaps_on && burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_req_i   <= '{rx_byte: b, frame_end: fe};
    do @(posedge clk_i); while (!in_ready_o);
    predict_byte(b, fe);
    bytes_sent++;
  endtask

  task automatic send_slice(input int lo, input int hi, input bit with_end);
    for (int i = lo; i <= hi; i++) send_byte(frame_buf[i], with_end && i == hi);
    if (with_end) frames_sent++;
  endtask

  task automatic send_frame();
    send_slice(0, frame_buf.size() - 1, 1'b1);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (response_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic idx, input logic [7:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx == mrrc_pkg::CfgSlaveAddr) exp_slave = val;
    else exp_count = val[6:0];
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic reconfigure(input logic [7:0] slave, input logic [6:0] count);
    wait_idle();
    write_cfg(mrrc_pkg::CfgSlaveAddr, slave);
    write_cfg(mrrc_pkg::CfgRegCount, {1'b0, count});
  endtask

  function automatic void seal_crc();
    logic [15:0] c;
    c = mrrc_pkg::CrcInit;
    void'(frame_buf.pop_back());
    void'(frame_buf.pop_back());
    foreach (frame_buf[i]) c = crc_byte(c, frame_buf[i]);
    frame_buf = {frame_buf, c[7:0], c[15:8]};
  endfunction

  function automatic void make_response(input logic [7:0] addr, input logic [7:0] func,
                                        input logic [7:0] cnt_byte, input int nregs);
    frame_buf.delete();
    frame_buf = {addr, func, cnt_byte};
    repeat (2 * nregs) frame_buf = {frame_buf, 8'($urandom_range(0, 255))};
    frame_buf = {frame_buf, 8'h00, 8'h00};
    seal_crc();
  endfunction

  function automatic void make_good();
    make_response(exp_slave, mrrc_pkg::FuncReadInput, {exp_count, 1'b0}, exp_count);
  endfunction

  function automatic logic [6:0] pick_count();
    int k;
    k = $urandom_range(0, 99);
    if (k < 5) return 7'd0;
    if (k < 65) return 7'($urandom_range(1, 4));
    if (k < 95) return 7'($urandom_range(5, 20));
    return 7'($urandom_range(100, 127));
  endfunction

  task automatic test_reset_config_frames();
    make_good();
    frame_buf[3] = 8'h00;
    frame_buf[4] = 8'h00;
    seal_crc();
    send_frame();
    make_good();
    frame_buf[3] = 8'hFF;
    frame_buf[4] = 8'hFF;
    seal_crc();
    send_frame();
  endtask

  task automatic test_header_faults();
    make_response(8'h02, mrrc_pkg::FuncReadInput, 8'd2, 1);
    send_frame();
    make_response(mrrc_pkg::SlaveAddrReset, 8'h03, 8'd2, 1);
    send_frame();
    make_response(mrrc_pkg::SlaveAddrReset, mrrc_pkg::FuncReadInput, 8'd4, 1);
    send_frame();
    make_response(8'hFE, 8'hFF, 8'h00, 1);
    send_frame();
  endtask

  task automatic test_crc_and_length();
    make_good();
    frame_buf[frame_buf.size() - 1] ^= 8'h80;
    send_frame();
    make_good();
    frame_buf[frame_buf.size() - 2] ^= 8'h01;
    send_frame();
    make_good();
    void'(frame_buf.pop_back());
    void'(frame_buf.pop_back());
    send_frame();
    frame_buf = {8'h01};
    send_frame();
    make_good();
    frame_buf = {frame_buf, 8'h5A, 8'hA5};
    send_frame();
  endtask

  task automatic test_config_extremes();
    reconfigure(8'h00, 7'd127);
    make_good();
    send_frame();
    reconfigure(8'hFF, 7'd2);
    make_good();
    send_frame();
    reconfigure(8'h80, 7'd0);
    make_good();
    send_frame();
    make_response(8'h80, mrrc_pkg::FuncReadInput, 8'd2, 1);
    send_frame();
  endtask

  task automatic test_midframe_config();
    reconfigure(8'hA5, 7'd3);
    make_good();
    send_slice(0, 4, 1'b0);
    wait_idle();
    write_cfg(mrrc_pkg::CfgRegCount, 8'd2);
    send_slice(5, frame_buf.size() - 1, 1'b1);
    make_good();
    send_frame();
  endtask

  task automatic test_long_frame();
    reconfigure(mrrc_pkg::SlaveAddrReset, 7'd1);
    frame_buf.delete();
    repeat (520) frame_buf = {frame_buf, 8'($urandom_range(0, 255))};
    send_frame();
  endtask

  task automatic test_random_traffic();
    int start;
    int k;
    int len;
    int pos;
    start = bytes_sent;
    while (bytes_sent - start < 300) begin
      if (exp_count > 7'd20 || $urandom_range(0, 7) == 0) begin
        gaps_on = ($urandom_range(0, 2) != 0);
        reconfigure(($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 255))
                                                 : mrrc_pkg::SlaveAddrReset,
                    pick_count());
      end
      make_good();
      k = $urandom_range(0, 99);
      if (k >= 70 && k < 76) begin
        pos = $urandom_range(0, 2);
        frame_buf[pos] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1) != 0) seal_crc();
      end else if (k >= 76 && k < 82) begin
        pos = $urandom_range(0, frame_buf.size() - 1);
        frame_buf[pos] ^= 8'h01 << $urandom_range(0, 7);
      end else if (k >= 82 && k < 88) begin
        len = $urandom_range(1, frame_buf.size() - 1);
        frame_buf = frame_buf[0:len-1];
      end else if (k >= 88 && k < 93) begin
        repeat ($urandom_range(1, 4)) frame_buf = {frame_buf, 8'($urandom_range(0, 255))};
      end else if (k >= 93) begin
        frame_buf.delete();
        repeat ($urandom_range(1, 12)) frame_buf = {frame_buf, 8'($urandom_range(0, 255))};
      end
      send_frame();
    end
  endtask

  initial begin
    exp_slave = mrrc_pkg::SlaveAddrReset;
    exp_count = mrrc_pkg::RegCountReset;
    clear_frame();
    foreach (status_tally[i]) status_tally[i] = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_config_frames();
    test_header_faults();
    test_crc_and_length();
    test_config_extremes();
    test_midframe_config();
    test_long_frame();
    test_random_traffic();
    wait_idle();
    $display("Sent %0d bytes in %0d frames; checked %0d registers and %0d frame statuses.",
             bytes_sent, frames_sent, regs_seen, status_seen);
    $display("Statuses ok/zero/length/slave/function/count/crc: %0d %0d %0d %0d %0d %0d %0d",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3],
             status_tally[4], status_tally[5], status_tally[6]);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d requests outstanding.", response_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> sim.f
hdl/mrrc_pkg.sv
hdl/mrrc_frame_check.sv
hdl/modbus_register_response_checker_top.sv
tb/sv/tb_modbus_register_response_checker_top.sv
